### rtl/iese_pkg.sv
// Shared types and constants for the integer expression stack evaluator.
// Token, operator and status codes, precedence lookup and the
// controller/datapath command and status records. No dependencies.
package iese_pkg;

  localparam logic [2:0] CMD_VALUE = 3'd0;
  localparam logic [2:0] CMD_OPEN  = 3'd1;
  localparam logic [2:0] CMD_CLOSE = 3'd2;
  localparam logic [2:0] CMD_OPER  = 3'd3;
  localparam logic [2:0] KIND_NONE = 3'd7;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_OR  = 4'd6;
  localparam logic [3:0] OP_XOR = 4'd7;
  localparam logic [3:0] OP_SHL = 4'd8;
  localparam logic [3:0] OP_SAR = 4'd9;
  localparam logic [3:0] OP_ROL = 4'd10;
  localparam logic [3:0] OP_ROR = 4'd11;
  localparam logic [3:0] OP_POS = 4'd12;
  localparam logic [3:0] OP_NEG = 4'd13;
  localparam logic [3:0] OP_ABS = 4'd14;
  localparam logic [3:0] OP_NOT = 4'd15;

  localparam logic [4:0] OPS_MUL     = 5'd2;
  localparam logic [4:0] OPS_BRACKET = 5'd16;

  localparam logic [3:0] PREC_MUL   = 4'd6;
  localparam logic [3:0] PREC_CLOSE = 4'd0;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNKNOWN  = 3'd1;
  localparam logic [2:0] ST_MISSING  = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic       cap_tok;
    logic       push_tok;
    logic       push_op;
    logic [4:0] op_data;
    logic       pop_op;
    logic       clear_zero;
    logic       ld_a;
    logic       ld_b;
    logic       ld_b_zero;
    logic       rd_sec;
    logic       alu_start;
    logic       wr_res;
    logic       wr_bin;
    logic       out_load;
    logic       out_zero;
    logic [2:0] out_status;
    logic       reset_all;
  } dp_cmd_t;

  typedef struct packed {
    logic       op_empty;
    logic       op_full;
    logic       val_empty;
    logic       val_one;
    logic       val_full;
    logic [4:0] op_top;
    logic       alu_done;
    logic       alu_div0;
  } dp_stat_t;

  function automatic logic [3:0] prec(input logic [3:0] op);
    logic [3:0] p;
    unique case (op)
      OP_ADD, OP_SUB:                 p = 4'd5;
      OP_MUL, OP_DIV, OP_MOD:         p = 4'd6;
      OP_AND:                         p = 4'd3;
      OP_OR:                          p = 4'd1;
      OP_XOR:                         p = 4'd2;
      OP_SHL, OP_SAR, OP_ROL, OP_ROR: p = 4'd4;
      default:                        p = 4'd8;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] flag(input logic [2:0] cur, input logic [2:0] s);
    return (cur == ST_OK) ? s : cur;
  endfunction

endpackage

### rtl/iese_if.sv
// Valid/ready channels for token requests and result requests.
// Depends on nothing.
interface iese_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [63:0] operand_value;
  logic [3:0]         op_code;
  logic               last_token;
  modport source (output valid, command, operand_value, op_code, last_token, input ready);
  modport sink (input valid, command, operand_value, op_code, last_token, output ready);
endinterface

interface iese_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [2:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

### rtl/iese_alu.sv
// Multi-cycle 64-bit integer unit: add, subtract, logic, shift and unary ops,
// a multiply built from 32x32 partial products and a radix-2 restoring divide. Uses iese_pkg.
module iese_alu import iese_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [3:0]  op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic        div0,
  output logic [63:0] res
);

  typedef enum logic [4:0] {
    A_IDLE   = 5'b00001,
    A_SIMPLE = 5'b00010,
    A_MUL    = 5'b00100,
    A_DIV    = 5'b01000,
    A_FIX    = 5'b10000
  } alu_state_t;

  alu_state_t  state_r, state_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        done_r, done_nxt;
  logic        div0_r, div0_nxt;
  logic [63:0] res_r, res_nxt;
  logic [1:0]  mstep_r, mstep_nxt;
  logic [63:0] p_r, p_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] nb_r, nb_nxt;
  logic        sa_r, sa_nxt;
  logic        sb_r, sb_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic [31:0]  mx, my;
  logic [63:0]  prod;
  logic [64:0]  rem_sh, rem_diff;
  logic         ge;
  logic [5:0]   sh;
  logic [127:0] rol_w, ror_w;
  logic [63:0]  simple_res;

  assign sh = b[5:0];
  assign rol_w = {a, a} << sh;
  assign ror_w = {a, a} >> sh;

  always_comb begin
    unique case (op_r)
      OP_ADD:  simple_res = a + b;
      OP_SUB:  simple_res = a - b;
      OP_AND:  simple_res = a & b;
      OP_OR:   simple_res = a | b;
      OP_XOR:  simple_res = a ^ b;
      OP_SHL:  simple_res = a << sh;
      OP_SAR:  simple_res = $unsigned($signed(a) >>> sh);
      OP_ROL:  simple_res = rol_w[127:64];
      OP_ROR:  simple_res = ror_w[63:0];
      OP_NEG:  simple_res = 64'd0 - a;
      OP_ABS:  simple_res = a[63] ? 64'd0 - a : a;
      OP_NOT:  simple_res = ~a;
      default: simple_res = a;
    endcase
  end

  always_comb begin
    unique case (mstep_r)
      2'd1:    begin mx = a[31:0];  my = b[63:32]; end
      2'd2:    begin mx = a[63:32]; my = b[31:0];  end
      default: begin mx = a[31:0];  my = b[31:0];  end
    endcase
  end
  assign prod = mx * my;

  assign rem_sh   = {rem_r, q_r[63]};
  assign rem_diff = rem_sh - {1'b0, nb_r};
  assign ge       = !rem_diff[64];

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    done_nxt  = 1'b0;
    div0_nxt  = div0_r;
    res_nxt   = res_r;
    mstep_nxt = mstep_r;
    p_nxt     = p_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    nb_nxt    = nb_r;
    sa_nxt    = sa_r;
    sb_nxt    = sb_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      A_IDLE: begin
        if (start) begin
          op_nxt = op;
          div0_nxt = 1'b0;
          if (op == OP_MUL) begin
            mstep_nxt = 2'd0;
            state_nxt = A_MUL;
          end else if (op == OP_DIV || op == OP_MOD) begin
            if (b == 64'd0) begin
              res_nxt  = 64'd0;
              div0_nxt = 1'b1;
              done_nxt = 1'b1;
            end else begin
              sa_nxt    = a[63];
              sb_nxt    = b[63];
              q_nxt     = a[63] ? 64'd0 - a : a;
              nb_nxt    = b[63] ? 64'd0 - b : b;
              rem_nxt   = 64'd0;
              cnt_nxt   = 6'd0;
              state_nxt = A_DIV;
            end
          end else begin
            state_nxt = A_SIMPLE;
          end
        end
      end
      A_SIMPLE: begin
        res_nxt   = simple_res;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      A_MUL: begin
        p_nxt     = prod;
        mstep_nxt = mstep_r + 2'd1;
        unique case (mstep_r)
          2'd0: ;
          2'd1: acc_nxt = p_r;
          2'd2: acc_nxt = {acc_r[63:32] + p_r[31:0], acc_r[31:0]};
          default: begin
            res_nxt   = {acc_r[63:32] + p_r[31:0], acc_r[31:0]};
            done_nxt  = 1'b1;
            state_nxt = A_IDLE;
          end
        endcase
      end
      A_DIV: begin
        rem_nxt = ge ? rem_diff[63:0] : rem_sh[63:0];
        q_nxt   = {q_r[62:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = A_FIX;
      end
      A_FIX: begin
        if (op_r == OP_DIV) res_nxt = (sa_r ^ sb_r) ? 64'd0 - q_r : q_r;
        else res_nxt = sa_r ? 64'd0 - rem_r : rem_r;
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      div0_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      div0_r  <= div0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    res_r   <= res_nxt;
    mstep_r <= mstep_nxt;
    p_r     <= p_nxt;
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    nb_r    <= nb_nxt;
    sa_r    <= sa_nxt;
    sb_r    <= sb_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign done = done_r;
  assign div0 = div0_r;
  assign res  = res_r;

endmodule

### rtl/iese_dp.sv
// Datapath: operator and value stack memories, their counts, operand
// registers, the arithmetic unit and the result register. Uses iese_pkg, iese_alu.
module iese_dp import iese_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic signed [63:0] tok_value,
  output logic signed [63:0] out_value,
  output logic [2:0]         out_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [4:0]  op_mem  [STACK_DEPTH];
  logic [63:0] val_mem [STACK_DEPTH];

  logic [CW-1:0] opcnt_r, opcnt_nxt;
  logic [CW-1:0] vcnt_r, vcnt_nxt;
  logic [4:0]    op_rdata_r;
  logic [63:0]   v_rdata_r;
  logic [63:0]   tok_r, a_r, b_r;
  logic [63:0]   out_value_r;
  logic [2:0]    out_status_r;

  logic          op_full, val_full;
  logic [CW-1:0] op_top_c, v_top_c, v_sec_c;
  logic [AW-1:0] op_raddr, v_raddr;
  logic          op_we, v_we;
  logic [AW-1:0] op_waddr, v_waddr;
  logic [63:0]   v_wdata;
  logic          alu_done, alu_div0;
  logic [63:0]   alu_res;

  assign op_full  = opcnt_r == CW'(STACK_DEPTH);
  assign val_full = vcnt_r == CW'(STACK_DEPTH);
  assign op_top_c = opcnt_r - CW'(1);
  assign v_top_c  = vcnt_r - CW'(1);
  assign v_sec_c  = vcnt_r - CW'(2);
  assign op_raddr = op_top_c[AW-1:0];
  assign v_raddr  = cmd.rd_sec ? v_sec_c[AW-1:0] : v_top_c[AW-1:0];

  always_comb begin
    opcnt_nxt = opcnt_r;
    vcnt_nxt  = vcnt_r;
    op_we     = 1'b0;
    op_waddr  = opcnt_r[AW-1:0];
    v_we      = 1'b0;
    v_waddr   = vcnt_r[AW-1:0];
    v_wdata   = tok_r;
    if (cmd.push_op && !op_full) begin
      op_we     = 1'b1;
      opcnt_nxt = opcnt_r + CW'(1);
    end
    if (cmd.pop_op) opcnt_nxt = op_top_c;
    if (cmd.push_tok && !val_full) begin
      v_we     = 1'b1;
      vcnt_nxt = vcnt_r + CW'(1);
    end
    if (cmd.wr_res) begin
      v_we    = 1'b1;
      v_wdata = alu_res;
      if (cmd.wr_bin) begin
        v_waddr  = v_sec_c[AW-1:0];
        vcnt_nxt = v_top_c;
      end else begin
        v_waddr = v_top_c[AW-1:0];
      end
    end
    if (cmd.clear_zero) begin
      v_we      = 1'b1;
      v_waddr   = '0;
      v_wdata   = 64'd0;
      opcnt_nxt = '0;
      vcnt_nxt  = CW'(1);
    end
    if (cmd.reset_all) begin
      opcnt_nxt = '0;
      vcnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_we) op_mem[op_waddr] <= cmd.op_data;
    op_rdata_r <= op_mem[op_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) val_mem[v_waddr] <= v_wdata;
    v_rdata_r <= val_mem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcnt_r <= '0;
      vcnt_r  <= '0;
    end else begin
      opcnt_r <= opcnt_nxt;
      vcnt_r  <= vcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_tok) tok_r <= $unsigned(tok_value);
    if (cmd.ld_a) a_r <= v_rdata_r;
    if (cmd.ld_b) b_r <= v_rdata_r;
    if (cmd.ld_b_zero) b_r <= 64'd0;
    if (cmd.out_load) begin
      out_value_r  <= cmd.out_zero ? 64'd0 : v_rdata_r;
      out_status_r <= cmd.out_status;
    end
  end

  iese_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.alu_start),
    .op    (op_rdata_r[3:0]),
    .a     (a_r),
    .b     (b_r),
    .done  (alu_done),
    .div0  (alu_div0),
    .res   (alu_res)
  );

  assign stat.op_empty  = opcnt_r == '0;
  assign stat.op_full   = op_full;
  assign stat.val_empty = vcnt_r == '0;
  assign stat.val_one   = vcnt_r == CW'(1);
  assign stat.val_full  = val_full;
  assign stat.op_top    = op_rdata_r;
  assign stat.alu_done  = alu_done;
  assign stat.alu_div0  = alu_div0;

  assign out_value  = $signed(out_value_r);
  assign out_status = out_status_r;

endmodule

### rtl/iese_ctrl.sv
// Controller: token decode, reduction sequencing, error latching and the
// result request handshake. Uses iese_pkg; drives iese_dp by dp_cmd_t.
module iese_ctrl import iese_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [2:0] in_command,
  input  logic [3:0] in_op_code,
  input  logic     in_last_token,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_PRE    = 14'b00000000000010,
    S_OPRD   = 14'b00000000000100,
    S_OPCHK  = 14'b00000000001000,
    S_VTOP   = 14'b00000000010000,
    S_VSEC   = 14'b00000000100000,
    S_VLOAD  = 14'b00000001000000,
    S_EXEC   = 14'b00000010000000,
    S_WAIT   = 14'b00000100000000,
    S_POST1  = 14'b00001000000000,
    S_POST2  = 14'b00010000000000,
    S_FINCHK = 14'b00100000000000,
    S_FINRD  = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic [2:0] prev_r, prev_nxt;
  logic [2:0] sprev_r, sprev_nxt;
  logic [2:0] err_r, err_nxt;
  logic       last_r, last_nxt;
  logic       pre_val_r, pre_val_nxt;
  logic       pre_mul_r, pre_mul_nxt;
  logic       red_r, red_nxt;
  logic [3:0] key_r, key_nxt;
  logic       post_val_r, post_val_nxt;
  logic       post_a_en_r, post_a_en_nxt;
  logic [4:0] post_a_r, post_a_nxt;
  logic       post_b_en_r, post_b_en_nxt;
  logic       pop_r, pop_nxt;
  logic       final_r, final_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [4:0] top;
  logic       unary;

  assign top   = dp_stat.op_top;
  assign unary = top[3:2] == 2'b11;

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    sprev_nxt     = sprev_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    pre_val_nxt   = pre_val_r;
    pre_mul_nxt   = pre_mul_r;
    red_nxt       = red_r;
    key_nxt       = key_r;
    post_val_nxt  = post_val_r;
    post_a_en_nxt = post_a_en_r;
    post_a_nxt    = post_a_r;
    post_b_en_nxt = post_b_en_r;
    pop_nxt       = pop_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dp_cmd        = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.cap_tok = 1'b1;
          last_nxt      = in_last_token;
          pre_val_nxt   = 1'b0;
          pre_mul_nxt   = 1'b0;
          red_nxt       = 1'b0;
          key_nxt       = PREC_MUL;
          post_val_nxt  = 1'b0;
          post_a_en_nxt = 1'b0;
          post_a_nxt    = OPS_MUL;
          post_b_en_nxt = 1'b0;
          pop_nxt       = 1'b0;
          if (err_r == ST_UNKNOWN || in_command > CMD_OPER) begin
            err_nxt   = ST_UNKNOWN;
            state_nxt = in_last_token ? S_FINCHK : S_IDLE;
          end else begin
            sprev_nxt = prev_r;
            prev_nxt  = in_command;
            state_nxt = S_PRE;
            unique case (in_command)
              CMD_VALUE: begin
                if (prev_r == CMD_VALUE) begin
                  pre_val_nxt = 1'b1;
                  pre_mul_nxt = 1'b1;
                  red_nxt     = 1'b1;
                end else if (prev_r == CMD_CLOSE) begin
                  red_nxt       = 1'b1;
                  post_val_nxt  = 1'b1;
                  post_a_en_nxt = 1'b1;
                end else begin
                  post_val_nxt = 1'b1;
                end
              end
              CMD_OPEN: begin
                post_a_en_nxt = 1'b1;
                if (prev_r == CMD_VALUE || (prev_r == CMD_CLOSE && sprev_r == CMD_VALUE)) begin
                  red_nxt       = 1'b1;
                  post_b_en_nxt = 1'b1;
                end else begin
                  post_a_nxt = OPS_BRACKET;
                end
              end
              CMD_CLOSE: begin
                red_nxt = 1'b1;
                key_nxt = PREC_CLOSE;
                pop_nxt = 1'b1;
              end
              default: begin
                pre_mul_nxt   = prev_r == CMD_VALUE && in_op_code >= OP_POS;
                red_nxt       = 1'b1;
                key_nxt       = prec(in_op_code);
                post_a_en_nxt = 1'b1;
                post_a_nxt    = {1'b0, in_op_code};
              end
            endcase
          end
        end
      end
      S_PRE: begin
        if (pre_val_r) begin
          dp_cmd.push_tok = 1'b1;
          if (dp_stat.val_full) err_nxt = flag(err_nxt, ST_OVERFLOW);
        end
        if (pre_mul_r) begin
          dp_cmd.push_op = 1'b1;
          dp_cmd.op_data = OPS_MUL;
          if (dp_stat.op_full) err_nxt = flag(err_nxt, ST_OVERFLOW);
        end
        state_nxt = red_r ? S_OPRD : S_POST1;
      end
      S_OPRD: begin
        if (final_r) state_nxt = (dp_stat.op_empty || dp_stat.val_empty) ? S_FINRD : S_OPCHK;
        else state_nxt = dp_stat.op_empty ? S_POST1 : S_OPCHK;
      end
      S_OPCHK: begin
        if (!final_r && (top[4] || !(key_r < prec(top[3:0])))) begin
          state_nxt = S_POST1;
        end else if (top[4]) begin
          dp_cmd.pop_op = 1'b1;
          state_nxt     = S_OPRD;
        end else if (dp_stat.val_empty || (!unary && dp_stat.val_one)) begin
          dp_cmd.clear_zero = 1'b1;
          err_nxt           = flag(err_r, ST_MISSING);
          state_nxt         = S_OPRD;
        end else begin
          state_nxt = S_VTOP;
        end
      end
      S_VTOP: state_nxt = S_VSEC;
      S_VSEC: begin
        if (unary) begin
          dp_cmd.ld_a      = 1'b1;
          dp_cmd.ld_b_zero = 1'b1;
          state_nxt        = S_EXEC;
        end else begin
          dp_cmd.ld_b   = 1'b1;
          dp_cmd.rd_sec = 1'b1;
          state_nxt     = S_VLOAD;
        end
      end
      S_VLOAD: begin
        dp_cmd.ld_a = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        dp_cmd.alu_start = 1'b1;
        state_nxt        = S_WAIT;
      end
      S_WAIT: begin
        if (dp_stat.alu_done) begin
          dp_cmd.wr_res = 1'b1;
          dp_cmd.wr_bin = !unary;
          dp_cmd.pop_op = 1'b1;
          if (dp_stat.alu_div0) err_nxt = flag(err_r, ST_DIV_ZERO);
          state_nxt = S_OPRD;
        end
      end
      S_POST1: begin
        if (post_val_r) begin
          dp_cmd.push_tok = 1'b1;
          if (dp_stat.val_full) err_nxt = flag(err_nxt, ST_OVERFLOW);
        end
        if (post_a_en_r) begin
          dp_cmd.push_op = 1'b1;
          dp_cmd.op_data = post_a_r;
          if (dp_stat.op_full) err_nxt = flag(err_nxt, ST_OVERFLOW);
        end
        state_nxt = S_POST2;
      end
      S_POST2: begin
        if (post_b_en_r) begin
          dp_cmd.push_op = 1'b1;
          dp_cmd.op_data = OPS_BRACKET;
          if (dp_stat.op_full) err_nxt = flag(err_r, ST_OVERFLOW);
        end
        if (pop_r && !dp_stat.op_empty) dp_cmd.pop_op = 1'b1;
        state_nxt = last_r ? S_FINCHK : S_IDLE;
      end
      S_FINCHK: begin
        if (err_r == ST_OK && !dp_stat.val_empty) begin
          final_nxt = 1'b1;
          state_nxt = S_OPRD;
        end else begin
          if (err_r == ST_OK) err_nxt = ST_MISSING;
          state_nxt = S_FINRD;
        end
      end
      S_FINRD: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.out_load   = 1'b1;
          dp_cmd.out_zero   = err_r != ST_OK || dp_stat.val_empty;
          dp_cmd.out_status = err_r;
          dp_cmd.reset_all  = 1'b1;
          out_valid_nxt     = 1'b1;
          prev_nxt          = KIND_NONE;
          sprev_nxt         = KIND_NONE;
          err_nxt           = ST_OK;
          final_nxt         = 1'b0;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= KIND_NONE;
      sprev_r     <= KIND_NONE;
      err_r       <= ST_OK;
      last_r      <= 1'b0;
      pre_val_r   <= 1'b0;
      pre_mul_r   <= 1'b0;
      red_r       <= 1'b0;
      key_r       <= PREC_CLOSE;
      post_val_r  <= 1'b0;
      post_a_en_r <= 1'b0;
      post_a_r    <= OPS_MUL;
      post_b_en_r <= 1'b0;
      pop_r       <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      sprev_r     <= sprev_nxt;
      err_r       <= err_nxt;
      last_r      <= last_nxt;
      pre_val_r   <= pre_val_nxt;
      pre_mul_r   <= pre_mul_nxt;
      red_r       <= red_nxt;
      key_r       <= key_nxt;
      post_val_r  <= post_val_nxt;
      post_a_en_r <= post_a_en_nxt;
      post_a_r    <= post_a_nxt;
      post_b_en_r <= post_b_en_nxt;
      pop_r       <= pop_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/integer_expression_stack_evaluator_unit.sv
// Top level of the integer infix expression evaluator.
// Uses iese_pkg, iese_if, iese_ctrl, iese_dp.
//
// Takes one token request at a time and returns one result request per token
// marked last. A token may trigger reduction steps; each step runs the
// arithmetic unit, which forms a multiply from three 32x32 partial products on
// one multiplier and a divide or modulo at one quotient bit a cycle. A last
// token adds the final reduction and the read-out of the result. The stacks
// are memories with registered reads. No clearing pass is needed after reset.
module integer_expression_stack_evaluator_unit import iese_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  iese_in_if.sink    in_chan,
  iese_out_if.source out_chan
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  iese_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_command    (in_chan.command),
    .in_op_code    (in_chan.op_code),
    .in_last_token (in_chan.last_token),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .dp_cmd        (dp_cmd),
    .dp_stat       (dp_stat)
  );

  iese_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .stat       (dp_stat),
    .tok_value  (in_chan.operand_value),
    .out_value  (out_chan.result_value),
    .out_status (out_chan.status)
  );

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid &&
      $stable(out_chan.result_value) && $stable(out_chan.status))
    else $error("result request changed while waiting");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != ST_OK |-> out_chan.result_value == 64'sd0)
    else $error("nonzero result with error status");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.status == ST_OK || out_chan.status == ST_UNKNOWN ||
      out_chan.status == ST_MISSING || out_chan.status == ST_DIV_ZERO ||
      out_chan.status == ST_OVERFLOW)
    else $error("bad status code");

endmodule

### tb/integer_expression_stack_evaluator_unit_test.sv
// Testbench for integer_expression_stack_evaluator_unit: infix token requests in, one
// result request per last token out, checked against an in-bench stack evaluator.
// Depends on iese_pkg, iese_if and the RTL of the unit.
module integer_expression_stack_evaluator_unit_test;
  import iese_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNKNOWN = 3'd4;
  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] operand;
    logic [3:0]  op;
    logic        last;
  } token_t;

  class expr_scoreboard;
    logic [4:0]  op_stack[DEPTH];
    logic [63:0] val_stack[DEPTH];
    int          op_cnt, val_cnt;
    logic [2:0]  prev_kind, prev2_kind, err;
    logic [63:0] exp_value[$];
    logic [2:0]  exp_status[$];
    int          errors, results, status_seen[8];

    function void clear();
      op_cnt = 0; val_cnt = 0; prev_kind = KIND_NONE; prev2_kind = KIND_NONE; err = ST_OK;
    endfunction

    function logic [3:0] rank(logic [3:0] op);
      case (op)
        OP_ADD, OP_SUB:                 return 4'd5;
        OP_MUL, OP_DIV, OP_MOD:         return 4'd6;
        OP_AND:                         return 4'd3;
        OP_OR:                          return 4'd1;
        OP_XOR:                         return 4'd2;
        OP_SHL, OP_SAR, OP_ROL, OP_ROR: return 4'd4;
        default:                        return 4'd8;
      endcase
    endfunction

    function void latch(logic [2:0] s);
      if (err == ST_OK) err = s;
    endfunction

    function void push_value(logic [63:0] v);
      if (val_cnt < DEPTH) begin val_stack[val_cnt] = v; val_cnt++; end
      else latch(ST_OVERFLOW);
    endfunction

    function void push_oper(logic [4:0] o);
      if (op_cnt < DEPTH) begin op_stack[op_cnt] = o; op_cnt++; end
      else latch(ST_OVERFLOW);
    endfunction

    function void wipe_to_zero();
      op_cnt = 0; val_cnt = 0; push_value(64'd0); latch(ST_MISSING);
    endfunction

    function logic [63:0] compute(logic [3:0] op, logic [63:0] a, logic [63:0] b);
      int n;
      n = int'(b[5:0]);
      case (op)
        OP_ADD: return a + b;
        OP_SUB: return a - b;
        OP_MUL: return a * b;
        OP_DIV, OP_MOD: begin
          if (b == 0) begin latch(ST_DIV_ZERO); return 0; end
          if (a == 64'h8000_0000_0000_0000 && b == '1)
            return (op == OP_DIV) ? 64'h8000_0000_0000_0000 : 64'd0;
          return (op == OP_DIV) ? $signed(a) / $signed(b) : $signed(a) % $signed(b);
        end
        OP_AND: return a & b;
        OP_OR:  return a | b;
        OP_XOR: return a ^ b;
        OP_SHL: return a << n;
        OP_SAR: return $signed(a) >>> n;
        OP_ROL: return (n == 0) ? a : ((a << n) | (a >> (64 - n)));
        OP_ROR: return (n == 0) ? a : ((a >> n) | (a << (64 - n)));
        OP_POS: return a;
        OP_NEG: return -a;
        OP_ABS: return a[63] ? -a : a;
        default: return ~a;
      endcase
    endfunction

    function void reduce_one();
      logic [4:0]  o;
      logic [63:0] b;
      if (val_cnt == 0 || op_cnt == 0) begin wipe_to_zero(); return; end
      o = op_stack[op_cnt-1];
      if (o >= OPS_BRACKET) begin op_cnt--; return; end
      if (o[3:0] >= OP_POS) begin
        val_stack[val_cnt-1] = compute(o[3:0], val_stack[val_cnt-1], 64'd0);
        op_cnt--;
        return;
      end
      val_cnt--;
      b = val_stack[val_cnt];
      if (val_cnt == 0) begin wipe_to_zero(); return; end
      val_stack[val_cnt-1] = compute(o[3:0], val_stack[val_cnt-1], b);
      op_cnt--;
    endfunction

    function bit top_oper();
      return op_cnt > 0 && op_stack[op_cnt-1] < OPS_BRACKET;
    endfunction

    function void reduce_above_mul();
      while (top_oper() && rank(op_stack[op_cnt-1][3:0]) > rank(OP_MUL)) reduce_one();
    endfunction

    function void note_token(token_t t);
      if (err != ST_UNKNOWN) begin
        case (t.command)
          CMD_VALUE: begin
            if (prev_kind == CMD_VALUE || prev_kind == CMD_CLOSE) begin
              if (prev_kind == CMD_VALUE) begin push_value(t.operand); push_oper(OPS_MUL); end
              reduce_above_mul();
              if (prev_kind == CMD_CLOSE) begin push_value(t.operand); push_oper(OPS_MUL); end
            end else push_value(t.operand);
          end
          CMD_OPEN: begin
            if (prev_kind == CMD_VALUE || (prev_kind == CMD_CLOSE && prev2_kind == CMD_VALUE)) begin
              reduce_above_mul();
              push_oper(OPS_MUL);
            end
            push_oper(OPS_BRACKET);
          end
          CMD_CLOSE: begin
            while (top_oper()) reduce_one();
            if (op_cnt > 0) op_cnt--;
          end
          CMD_OPER: begin
            if (prev_kind == CMD_VALUE && t.op >= OP_POS) push_oper(OPS_MUL);
            while (top_oper() && rank(t.op) < rank(op_stack[op_cnt-1][3:0])) reduce_one();
            push_oper({1'b0, t.op});
          end
          default: err = ST_UNKNOWN;
        endcase
        if (t.command <= CMD_OPER) begin prev2_kind = prev_kind; prev_kind = t.command; end
      end
      if (!t.last) return;
      if (err == ST_OK) begin
        if (val_cnt == 0) latch(ST_MISSING);
        else while (op_cnt > 0 && val_cnt > 0) reduce_one();
      end
      exp_value.push_back((err == ST_OK && val_cnt > 0) ? val_stack[val_cnt-1] : 64'd0);
      exp_status.push_back(err);
      clear();
    endfunction

    function void check_result(logic [63:0] v, logic [2:0] s);
      logic [63:0] ev;
      logic [2:0]  es;
      results++;
      if (exp_value.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d status=%0d", $time, $signed(v), s);
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      status_seen[es]++;
      if (v !== ev) begin
        errors++;
        $display("%0t: result_value expected %0d actual %0d", $time, $signed(ev), $signed(v));
      end
      if (s !== es) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, es, s);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  iese_in_if  in_chan();
  iese_out_if out_chan();

  integer_expression_stack_evaluator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  expr_scoreboard sb = new();
  token_t  pending_tokens[$];
  int      phase;
  int      sent;
  bit      stall_request;
  int      quiet_cycles;

  initial begin
    in_chan.valid = 1'b0; in_chan.command = CMD_VALUE; in_chan.operand_value = '0;
    in_chan.op_code = OP_ADD; in_chan.last_token = 1'b0;
    out_chan.ready = 1'b0;
  end

  function int send_gap();
    int pct;
    pct = (phase == 0) ? 29 : (phase == 1) ? 82 : 0;
    if ($urandom_range(99) >= pct) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic send_token(token_t t);
    int gap;
    gap = send_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.command <= t.command;
    in_chan.operand_value <= t.operand;
    in_chan.op_code <= t.op;
    in_chan.last_token <= t.last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_token(t);
    sent++;
  endtask

  task automatic flush_tokens();
    while (pending_tokens.size() > 0) send_token(pending_tokens.pop_front());
  endtask

  function automatic token_t tok(logic [2:0] c, logic [63:0] v = 0, logic [3:0] o = OP_ADD,
                                 logic l = 1'b0);
    token_t t;
    t.command = c; t.operand = v; t.op = o; t.last = l;
    return t;
  endfunction

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'h8000_0000_0000_0000;
      2: return 64'h7fff_ffff_ffff_ffff;
      3: return {64{1'b1}} - 64'($urandom_range(2));
      default: return 64'($urandom_range(20));
    endcase
  endfunction

  function automatic void add_term(int nest);
    if ($urandom_range(3) == 0)
      pending_tokens.push_back(tok(CMD_OPER, 0, 4'($urandom_range(12, 15))));
    if (nest > 0 && $urandom_range(3) == 0) begin
      pending_tokens.push_back(tok(CMD_OPEN));
      add_expr(nest - 1);
      pending_tokens.push_back(tok(CMD_CLOSE));
      if ($urandom_range(5) == 0) pending_tokens.push_back(tok(CMD_VALUE, rand_operand()));
    end else begin
      pending_tokens.push_back(tok(CMD_VALUE, rand_operand()));
      if ($urandom_range(9) == 0) pending_tokens.push_back(tok(CMD_VALUE, rand_operand()));
    end
  endfunction

  function automatic void add_expr(int nest);
    int terms;
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) pending_tokens.push_back(tok(CMD_OPER, 0, 4'($urandom_range(0, 11))));
      add_term(nest);
    end
  endfunction

  task automatic random_expression();
    token_t t;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        t = tok(3'($urandom_range(7)), {$urandom, $urandom}, 4'($urandom_range(15)), 1'b0);
        pending_tokens.push_back(t);
      end
    end else add_expr(2);
    if ($urandom_range(19) == 0 && pending_tokens.size() > 1) void'(pending_tokens.pop_back());
    pending_tokens[pending_tokens.size()-1].last = 1'b1;
    flush_tokens();
  endtask

  task automatic directed_tokens();
    // implicit multiply between values and brackets, right-binding equal precedence
    pending_tokens = '{tok(CMD_VALUE, 7), tok(CMD_OPEN), tok(CMD_VALUE, 3),
                       tok(CMD_OPER, 0, OP_SUB), tok(CMD_VALUE, 5), tok(CMD_CLOSE),
                       tok(CMD_VALUE, 2), tok(CMD_OPER, 0, OP_SUB), tok(CMD_VALUE, 1, OP_ADD, 1)};
    flush_tokens();
    for (int o = 0; o < 16; o++) begin
      pending_tokens = '{tok(CMD_VALUE, 64'h8000_0000_0000_0000), tok(CMD_OPER, 0, 4'(o)),
                         tok(CMD_VALUE, {64{1'b1}}, OP_ADD, 1)};
      flush_tokens();
    end
    pending_tokens = '{tok(CMD_VALUE, 64'h7fff_ffff_ffff_ffff), tok(CMD_OPER, 0, OP_DIV),
                       tok(CMD_VALUE, 0, OP_ADD, 1)};
    flush_tokens();
    pending_tokens = '{tok(CMD_VALUE, 9), tok(CMD_OPER, 0, OP_SHL), tok(CMD_VALUE, 65),
                       tok(CMD_OPER, 0, OP_ABS), tok(CMD_VALUE, 3, OP_ADD, 1)};
    flush_tokens();
    pending_tokens = '{tok(CMD_OPER, 0, OP_ADD), tok(CMD_VALUE, 4, OP_ADD, 1)};
    flush_tokens();
    pending_tokens = '{tok(CMD_CLOSE, 0, OP_ADD, 1)};
    flush_tokens();
    pending_tokens = '{tok(CMD_VALUE, 1), tok(CMD_CLOSE), tok(CMD_OPEN), tok(CMD_OPEN),
                       tok(CMD_VALUE, 6, OP_ADD, 1)};
    flush_tokens();
    pending_tokens = '{tok(CMD_VALUE, 2), tok(CMD_UNKNOWN), tok(CMD_VALUE, 3, OP_ADD, 1)};
    flush_tokens();
    repeat (DEPTH + 1) pending_tokens.push_back(tok(CMD_OPEN));
    pending_tokens.push_back(tok(CMD_VALUE, 5, OP_ADD, 1));
    flush_tokens();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.result_value, out_chan.status);
      if (stall_request) begin
        stall_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (phase == 0) out_chan.ready <= ($urandom_range(99) >= 82);
      else if (phase == 1) out_chan.ready <= ($urandom_range(99) >= 29);
      else out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("integer_expression_stack_evaluator_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    phase = 2;
    sent = 0;
    stall_request = 1'b0;
    quiet_cycles = 0;
    sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_tokens();
    for (int p = 0; p < 3; p++) begin
      phase = p;
      if (p == 2) stall_request = 1'b1;
      while (sent < (p + 1) * 350) random_expression();
    end
    in_chan.valid <= 1'b0;
    while (sb.exp_value.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d tokens, %0d results: ok %0d, unknown %0d, missing %0d, div0 %0d, overflow %0d",
             sent, sb.results, sb.status_seen[ST_OK], sb.status_seen[ST_UNKNOWN],
             sb.status_seen[ST_MISSING], sb.status_seen[ST_DIV_ZERO], sb.status_seen[ST_OVERFLOW]);
    if (sb.errors == 0) $display("integer_expression_stack_evaluator_unit_test: PASS");
    else $display("integer_expression_stack_evaluator_unit_test: FAIL");
    $finish;
  end
endmodule

### sim.f
rtl/iese_pkg.sv
rtl/iese_if.sv
rtl/iese_alu.sv
rtl/iese_dp.sv
rtl/iese_ctrl.sv
rtl/integer_expression_stack_evaluator_unit.sv
tb/integer_expression_stack_evaluator_unit_test.sv
